FILE: rtl/core/tclc_pkg.sv
// Shared types, constants and the power-table generator for the lux calculator.
// Used by every module under rtl/core except tclc_queue; depends on nothing.
package tclc_pkg;

	localparam int CountW = 16;
	localparam int ScaleW = 13;
	localparam int LuxW   = 20;
	localparam int BandW  = 3;
	localparam int FracW  = 13;
	localparam int RatioW = 16;

	localparam logic [RatioW-1:0] RatioMax = 16'hFFFF;
	localparam logic [RatioW-1:0] Limit0   = 16'd8192;
	localparam logic [RatioW-1:0] Limit1   = 16'd9994;
	localparam logic [RatioW-1:0] Limit2   = 16'd13107;
	localparam logic [RatioW-1:0] Limit3   = 16'd21299;

	localparam logic [BandW-1:0] BandLow  = 3'd0;
	localparam logic [BandW-1:0] BandMid1 = 3'd1;
	localparam logic [BandW-1:0] BandMid2 = 3'd2;
	localparam logic [BandW-1:0] BandMid3 = 3'd3;
	localparam logic [BandW-1:0] BandOff  = 3'd4;

	// Coefficients scaled by 2^16.
	localparam logic [15:0] CoefB0 = 16'd31877;
	localparam logic [15:0] CoefP0 = 16'd65012;
	localparam logic [15:0] CoefB1 = 16'd23488;
	localparam logic [15:0] CoefR1 = 16'd32506;
	localparam logic [15:0] CoefB2 = 16'd13422;
	localparam logic [15:0] CoefR2 = 16'd16043;
	localparam logic [15:0] CoefB3 = 16'd1531;
	localparam logic [15:0] CoefR3 = 16'd1174;

	localparam logic [LuxW-1:0] LuxMax = 20'hFFFFF;

	typedef struct packed {
		logic [CountW-1:0] bcount;
		logic [CountW-1:0] icount;
		logic [BandW-1:0]  band;
		logic [FracW-1:0]  frac;
	} tclc_item_t;

	// Largest y with y^5 * (2n)^7 <= i^7 * 65536^5, that is floor(65536 * (i/2n)^1.4).
	function automatic logic [15:0] pow_entry(input int i, input int n);
		logic [191:0] lhs;
		logic [191:0] rhs;
		int lo;
		int hi;
		int mid;
		int k;
		rhs = 192'd1;
		for (k = 0; k < 7; k++) rhs = rhs * 192'(i);
		for (k = 0; k < 5; k++) rhs = rhs * 192'(65536);
		lo = 0;
		hi = 65535;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = 192'd1;
			for (k = 0; k < 5; k++) lhs = lhs * 192'(mid);
			for (k = 0; k < 7; k++) lhs = lhs * 192'(2 * n);
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return 16'(lo);
	endfunction

endpackage

FILE: rtl/core/two_channel_lux_calculator_core.sv
// Two-channel lux calculator: one broadband/infrared count pair in, one lux result out.
// Throughput is one pair per cycle when nothing stalls, through the 16-stage divider and 7-stage back pipeline.
// The front stalls only when the 4-entry queue is full; the back only on a held output.
// Reset clears all valid bits and the queue, and sets lux_scale to 256 (unity in Q5.8).
// Depends on tclc_pkg, tclc_front, tclc_queue and tclc_back.
module two_channel_lux_calculator_core #(
	parameter int POWER_TABLE_ENTRIES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tclc_pkg::ScaleW-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tclc_pkg::CountW-1:0]       broadband_count,
	input  logic [tclc_pkg::CountW-1:0]       infrared_count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tclc_pkg::LuxW-1:0]         lux_value,
	output logic [tclc_pkg::BandW-1:0]        ratio_band,
	output logic                              saturated
);

	localparam int IdxW   = $clog2(POWER_TABLE_ENTRIES + 1);
	localparam int ItemW  = $bits(tclc_pkg::tclc_item_t);
	localparam int EntryW = ItemW + IdxW;

	logic [tclc_pkg::ScaleW-1:0] lux_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lux_scale_q <= tclc_pkg::ScaleW'(256);
		end else if (cfg_valid && cfg_ready) begin
			lux_scale_q <= cfg_data;
		end
	end

	logic                 q_full;
	logic                 q_empty;
	logic                 front_adv;
	logic                 push;
	tclc_pkg::tclc_item_t f_item;
	logic [IdxW-1:0]      f_idx;
	logic [EntryW-1:0]    q_rdata;
	logic                 back_adv;
	logic                 pop;

	assign front_adv = !q_full;
	assign in_ready  = front_adv;

	tclc_front #(
		.TableEntries(POWER_TABLE_ENTRIES),
		.IdxW(IdxW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.broadband_count(broadband_count),
		.infrared_count(infrared_count),
		.advance(front_adv),
		.push(push),
		.item(f_item),
		.idx(f_idx)
	);

	tclc_queue #(
		.Width(EntryW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata({f_item, f_idx}),
		.pop(pop),
		.rdata(q_rdata),
		.full(q_full),
		.empty(q_empty)
	);

	assign pop = back_adv && !q_empty;

	tclc_back #(
		.TableEntries(POWER_TABLE_ENTRIES),
		.IdxW(IdxW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(!q_empty),
		.item(tclc_pkg::tclc_item_t'(q_rdata[EntryW-1:IdxW])),
		.idx(q_rdata[IdxW-1:0]),
		.lux_scale(lux_scale_q),
		.advance(back_adv),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lux_value(lux_value),
		.ratio_band(ratio_band),
		.saturated(saturated)
	);

endmodule

FILE: rtl/core/tclc_front.sv
// Front part: input register, pipelined restoring divider for the ratio, and
// band classification with table position. Depends on tclc_pkg.
module tclc_front #(
	parameter int TableEntries = 64,
	parameter int IdxW = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [tclc_pkg::CountW-1:0]       broadband_count,
	input  logic [tclc_pkg::CountW-1:0]       infrared_count,
	input  logic                              advance,
	output logic                              push,
	output tclc_pkg::tclc_item_t              item,
	output logic [IdxW-1:0]                   idx
);

	localparam int Steps = tclc_pkg::RatioW;
	localparam int PosW  = tclc_pkg::RatioW + $clog2(TableEntries + 1);

	logic                        v_q    [0:Steps];
	logic [tclc_pkg::CountW-1:0] b_q    [0:Steps];
	logic [tclc_pkg::CountW-1:0] r_q    [0:Steps];
	logic [tclc_pkg::CountW:0]   rem_q  [0:Steps];
	logic [tclc_pkg::CountW-1:0] low_q  [0:Steps];
	logic [tclc_pkg::RatioW-1:0] quo_q  [0:Steps];
	logic                        ovf_q  [0:Steps];

	logic                        v_cls_q;
	tclc_pkg::tclc_item_t        item_q;
	logic [IdxW-1:0]             idx_q;

	// Stage 0 takes the transfer; the quotient fits 16 bits unless r >= 4b.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (advance) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			b_q[0]   <= broadband_count;
			r_q[0]   <= infrared_count;
			rem_q[0] <= {3'b000, infrared_count[15:2]};
			low_q[0] <= {infrared_count[1:0], 14'd0};
			quo_q[0] <= '0;
			ovf_q[0] <= ({2'b00, infrared_count} >= {broadband_count, 2'b00});
		end
	end

	for (genvar k = 1; k <= Steps; k++) begin : g_div
		logic [tclc_pkg::CountW:0] trial;
		logic                      take;
		assign trial = {rem_q[k-1][tclc_pkg::CountW-1:0], low_q[k-1][tclc_pkg::CountW-1]};
		assign take  = (trial >= {1'b0, b_q[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (advance) begin
				v_q[k] <= v_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				b_q[k]   <= b_q[k-1];
				r_q[k]   <= r_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
				low_q[k] <= {low_q[k-1][tclc_pkg::CountW-2:0], 1'b0};
				rem_q[k] <= take ? (trial - {1'b0, b_q[k-1]}) : trial;
				quo_q[k] <= {quo_q[k-1][tclc_pkg::RatioW-2:0], take};
			end
		end
	end

	logic [tclc_pkg::RatioW-1:0] ratio;
	logic [tclc_pkg::BandW-1:0]  band;
	logic [PosW-1:0]             pos;
	logic [PosW-1:0]             pos_idx;

	always_comb begin
		ratio   = ovf_q[Steps] ? tclc_pkg::RatioMax : quo_q[Steps];
		pos     = PosW'(ratio) * PosW'(TableEntries);
		pos_idx = pos >> tclc_pkg::FracW;
		priority if (b_q[Steps] == '0) band = tclc_pkg::BandOff;
		else if (ratio <= tclc_pkg::Limit0) band = tclc_pkg::BandLow;
		else if (ratio <= tclc_pkg::Limit1) band = tclc_pkg::BandMid1;
		else if (ratio <= tclc_pkg::Limit2) band = tclc_pkg::BandMid2;
		else if (ratio <= tclc_pkg::Limit3) band = tclc_pkg::BandMid3;
		else band = tclc_pkg::BandOff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_cls_q <= 1'b0;
		end else if (advance) begin
			v_cls_q <= v_q[Steps];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_q.bcount <= b_q[Steps];
			item_q.icount <= r_q[Steps];
			item_q.band   <= band;
			// The top of the table is reached at ratio 0.5 and above.
			if (pos_idx >= PosW'(TableEntries)) begin
				idx_q       <= IdxW'(TableEntries);
				item_q.frac <= '0;
			end else begin
				idx_q       <= pos_idx[IdxW-1:0];
				item_q.frac <= pos[tclc_pkg::FracW-1:0];
			end
		end
	end

	assign push = advance && v_cls_q;
	assign item = item_q;
	assign idx  = idx_q;

endmodule

FILE: rtl/core/tclc_queue.sv
// Short FIFO between the front and back parts, four entries deep.
// Depends on nothing but its width parameter.
module tclc_queue #(
	parameter int Width = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int Depth = 4;
	localparam int PtrW  = 2;

	logic [Width-1:0] mem_q [0:Depth-1];
	logic [PtrW-1:0]  wptr_q;
	logic [PtrW-1:0]  rptr_q;
	logic [PtrW:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rdata = mem_q[rptr_q];
	assign full  = (count_q == (PtrW+1)'(Depth));
	assign empty = (count_q == '0);

endmodule

FILE: rtl/core/tclc_back.sv
// Back part: power-table interpolation, band formula, scaling, rounding and
// saturation into the output register. Depends on tclc_pkg.
module tclc_back #(
	parameter int TableEntries = 64,
	parameter int IdxW = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  tclc_pkg::tclc_item_t          item,
	input  logic [IdxW-1:0]               idx,
	input  logic [tclc_pkg::ScaleW-1:0]   lux_scale,
	output logic                          advance,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tclc_pkg::LuxW-1:0]     lux_value,
	output logic [tclc_pkg::BandW-1:0]    ratio_band,
	output logic                          saturated
);

	localparam int RomW = $clog2(TableEntries + 2);

	// The extra top entry repeats the last one so idx+1 never leaves the table.
	logic [15:0] rom [0:TableEntries+1];
	for (genvar i = 0; i <= TableEntries + 1; i++) begin : g_rom
		localparam int Src = (i > TableEntries) ? TableEntries : i;
		localparam logic [15:0] Entry = tclc_pkg::pow_entry(Src, TableEntries);
		assign rom[i] = Entry;
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	assign advance = !v_s7 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (advance) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	// Stage 1: table read and band-formula products.
	logic [RomW-1:0] ra;
	logic [RomW-1:0] rb;
	logic [15:0]     ca;
	logic [15:0]     cr;
	assign ra = RomW'(idx);
	assign rb = RomW'(idx) + 1'b1;

	always_comb begin
		unique case (item.band)
			tclc_pkg::BandMid1: begin ca = tclc_pkg::CoefB1; cr = tclc_pkg::CoefR1; end
			tclc_pkg::BandMid2: begin ca = tclc_pkg::CoefB2; cr = tclc_pkg::CoefR2; end
			tclc_pkg::BandMid3: begin ca = tclc_pkg::CoefB3; cr = tclc_pkg::CoefR3; end
			default:            begin ca = '0; cr = '0; end
		endcase
	end

	logic [15:0]                   a_s1, dlt_s1;
	logic [31:0]                   cab_s1, crr_s1;
	logic [tclc_pkg::FracW-1:0]    frac_s1;
	logic [tclc_pkg::CountW-1:0]   b_s1, b_s2, b_s3, b_s4;
	logic [tclc_pkg::BandW-1:0]    band_s1, band_s2, band_s3, band_s4, band_s5, band_s6;

	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1    <= rom[ra];
			dlt_s1  <= rom[rb] - rom[ra];
			cab_s1  <= 32'(item.bcount) * 32'(ca);
			crr_s1  <= 32'(item.icount) * 32'(cr);
			frac_s1 <= item.frac;
			b_s1    <= item.bcount;
			band_s1 <= item.band;
		end
	end

	// Stage 2: interpolation product and clamped linear formula.
	logic [28:0] interp_s2;
	logic [15:0] a_s2;
	logic [30:0] lin_s2, lin_s3, lin_s4;
	logic [32:0] diff;
	assign diff = {1'b0, cab_s1} - {1'b0, crr_s1};

	always_ff @(posedge clk) begin
		if (advance) begin
			interp_s2 <= 29'(dlt_s1) * 29'(frac_s1);
			a_s2      <= a_s1;
			lin_s2    <= diff[32] ? '0 : diff[30:0];
			b_s2      <= b_s1;
			band_s2   <= band_s1;
		end
	end

	// Stage 3: ratio^1.4 times its coefficient.
	logic [16:0] pw;
	logic [32:0] m_s3;
	assign pw = 17'(a_s2) + 17'(interp_s2 >> tclc_pkg::FracW);

	always_ff @(posedge clk) begin
		if (advance) begin
			m_s3    <= 33'(pw) * 33'(tclc_pkg::CoefP0);
			lin_s3  <= lin_s2;
			b_s3    <= b_s2;
			band_s3 <= band_s2;
		end
	end

	// Stage 4: per-count term of the lowest band, always positive.
	logic [32:0] d_s4;
	always_ff @(posedge clk) begin
		if (advance) begin
			d_s4    <= {1'b0, tclc_pkg::CoefB0, 16'd0} - m_s3;
			lin_s4  <= lin_s3;
			b_s4    <= b_s3;
			band_s4 <= band_s3;
		end
	end

	// Stage 5: accumulator in units of 2^-32 lux.
	logic [47:0] acc_s5;
	always_ff @(posedge clk) begin
		if (advance) begin
			unique case (band_s4)
				tclc_pkg::BandLow: acc_s5 <= 48'(b_s4) * 48'(d_s4[31:0]);
				tclc_pkg::BandMid1,
				tclc_pkg::BandMid2,
				tclc_pkg::BandMid3: acc_s5 <= {1'b0, lin_s4, 16'd0};
				default:            acc_s5 <= '0;
			endcase
			band_s5 <= band_s4;
		end
	end

	// Stage 6: scale as two partial products.
	logic [36:0] plo_s6, phi_s6;
	always_ff @(posedge clk) begin
		if (advance) begin
			plo_s6  <= 37'(acc_s5[23:0]) * 37'(lux_scale);
			phi_s6  <= 37'(acc_s5[47:24]) * 37'(lux_scale);
			band_s6 <= band_s5;
		end
	end

	// Stage 7: combine, round half up, saturate; this is the output register.
	logic [61:0] sum;
	logic [21:0] lux_full;
	assign sum      = {1'b0, phi_s6, 24'd0} + 62'(plo_s6) + (62'd1 << 39);
	assign lux_full = sum[61:40];

	logic [tclc_pkg::LuxW-1:0]  lux_s7;
	logic [tclc_pkg::BandW-1:0] band_s7;
	logic                       sat_s7;
	always_ff @(posedge clk) begin
		if (advance) begin
			band_s7 <= band_s6;
			if (lux_full > 22'(tclc_pkg::LuxMax)) begin
				lux_s7 <= tclc_pkg::LuxMax;
				sat_s7 <= 1'b1;
			end else begin
				lux_s7 <= lux_full[tclc_pkg::LuxW-1:0];
				sat_s7 <= 1'b0;
			end
		end
	end

	assign out_valid  = v_s7;
	assign lux_value  = lux_s7;
	assign ratio_band = band_s7;
	assign saturated  = sat_s7;

endmodule

FILE: dv/two_channel_lux_calculator_core_test.sv
// Self-checking testbench for two_channel_lux_calculator_core: directed table, then random pairs.
// Expected lux values come from an in-bench integer predictor; depends on tclc_pkg and the RTL.
module two_channel_lux_calculator_core_test;

	localparam int PowEntries = 64;
	localparam int DrainCycles = 60;
	localparam int StallLimit = 5000;

	typedef struct {
		logic [tclc_pkg::CountW-1:0] bb;
		logic [tclc_pkg::CountW-1:0] ir;
		bit                          typed;
		logic [tclc_pkg::LuxW-1:0]   lux;
		logic [tclc_pkg::BandW-1:0]  band;
		logic                        sat;
	} pair_t;

	typedef struct {
		logic [tclc_pkg::LuxW-1:0]  lux;
		logic [tclc_pkg::BandW-1:0] band;
		logic                       sat;
	} lux_result_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [tclc_pkg::ScaleW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [tclc_pkg::CountW-1:0] broadband_count;
	logic [tclc_pkg::CountW-1:0] infrared_count;
	logic out_valid;
	logic out_ready;
	logic [tclc_pkg::LuxW-1:0] lux_value;
	logic [tclc_pkg::BandW-1:0] ratio_band;
	logic saturated;

	two_channel_lux_calculator_core #(.POWER_TABLE_ENTRIES(PowEntries)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.broadband_count(broadband_count),
		.infrared_count(infrared_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lux_value(lux_value),
		.ratio_band(ratio_band),
		.saturated(saturated)
	);

	logic [15:0] power_rom [0:PowEntries];
	logic [tclc_pkg::ScaleW-1:0] scale_now;
	pair_t pending_pairs[$];
	pair_t held_pair;
	lux_result_t expected_lux[$];
	int idle_pct;
	int errors;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Bitwise search for the largest y with y^5 * (2N)^7 <= i^7 * 2^80.
	function automatic logic [15:0] power_floor(input int i);
		logic [191:0] bound;
		logic [191:0] probe;
		logic [15:0] y;
		logic [15:0] trial;
		int k;
		bound = 192'(i) ** 7;
		bound = bound << 80;
		y = '0;
		for (int bit_pos = 15; bit_pos >= 0; bit_pos--) begin
			trial = y | (16'd1 << bit_pos);
			probe = 192'd1;
			for (k = 0; k < 5; k++) probe = probe * 192'(trial);
			for (k = 0; k < 7; k++) probe = probe * 192'(2 * PowEntries);
			if (probe <= bound) y = trial;
		end
		return y;
	endfunction

	function automatic lux_result_t predict_lux(input logic [tclc_pkg::CountW-1:0] bb,
			input logic [tclc_pkg::CountW-1:0] ir, input logic [tclc_pkg::ScaleW-1:0] scale);
		lux_result_t res;
		logic [31:0] ratio;
		logic [63:0] pos;
		logic [63:0] idx;
		logic [63:0] frac;
		logic [63:0] pw;
		logic [63:0] ulux;
		longint acc;
		res.lux = '0;
		res.band = tclc_pkg::BandOff;
		res.sat = 1'b0;
		if (bb == 0) return res;
		ratio = ({16'd0, ir} << 14) / {16'd0, bb};
		if (ratio > 32'(tclc_pkg::RatioMax)) ratio = 32'(tclc_pkg::RatioMax);
		if (ratio <= 32'(tclc_pkg::Limit0)) begin
			pos = 64'(ratio) * PowEntries;
			idx = pos >> 13;
			frac = pos & 64'd8191;
			if (idx >= PowEntries) pw = 64'(power_rom[PowEntries]);
			else pw = 64'(power_rom[idx]) +
				(((64'(power_rom[idx + 1]) - 64'(power_rom[idx])) * frac) >> 13);
			res.band = tclc_pkg::BandLow;
			acc = longint'(64'(bb) * 31877 * 65536) - longint'(64'(bb) * 65012 * pw);
		end else if (ratio <= 32'(tclc_pkg::Limit1)) begin
			res.band = tclc_pkg::BandMid1;
			acc = (longint'(64'(bb) * 23488) - longint'(64'(ir) * 32506)) * 65536;
		end else if (ratio <= 32'(tclc_pkg::Limit2)) begin
			res.band = tclc_pkg::BandMid2;
			acc = (longint'(64'(bb) * 13422) - longint'(64'(ir) * 16043)) * 65536;
		end else if (ratio <= 32'(tclc_pkg::Limit3)) begin
			res.band = tclc_pkg::BandMid3;
			acc = (longint'(64'(bb) * 1531) - longint'(64'(ir) * 1174)) * 65536;
		end else begin
			return res;
		end
		if (acc < 0) acc = 0;
		ulux = (64'(acc) * 64'(scale) + (64'd1 << 39)) >> 40;
		if (ulux > 64'(tclc_pkg::LuxMax)) begin
			res.lux = tclc_pkg::LuxMax;
			res.sat = 1'b1;
		end else begin
			res.lux = ulux[tclc_pkg::LuxW-1:0];
		end
		return res;
	endfunction

	// Input side: keep valid and payload steady until the transfer, then maybe idle.
	always @(posedge clk) begin
		logic next_valid;
		lux_result_t res;
		if (arst_n) begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				if (held_pair.typed) begin
					res.lux = held_pair.lux;
					res.band = held_pair.band;
					res.sat = held_pair.sat;
				end else begin
					res = predict_lux(held_pair.bb, held_pair.ir, scale_now);
				end
				expected_lux.push_back(res);
				next_valid = 1'b0;
			end
			if (!next_valid && pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
				held_pair = pending_pairs.pop_front();
				broadband_count <= held_pair.bb;
				infrared_count <= held_pair.ir;
				next_valid = 1'b1;
			end
			in_valid <= next_valid;
		end
	end

	// Output side: check each transfer against the oldest expectation.
	always @(posedge clk) begin
		lux_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_lux.size() == 0) begin
					$display("%0t: unexpected result lux=%0d band=%0d sat=%0d", $time,
						lux_value, ratio_band, saturated);
					errors++;
				end else begin
					want = expected_lux.pop_front();
					if (lux_value !== want.lux) begin
						$display("%0t: lux_value expected %0d actual %0d", $time, want.lux,
							lux_value);
						errors++;
					end
					if (ratio_band !== want.band) begin
						$display("%0t: ratio_band expected %0d actual %0d", $time, want.band,
							ratio_band);
						errors++;
					end
					if (saturated !== want.sat) begin
						$display("%0t: saturated expected %0d actual %0d", $time, want.sat,
							saturated);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_pairs.size() > 0 || in_valid || expected_lux.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_scale(input logic [tclc_pkg::ScaleW-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		scale_now = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_pair(input logic [tclc_pkg::CountW-1:0] bb,
			input logic [tclc_pkg::CountW-1:0] ir);
		pair_t p;
		p.bb = bb;
		p.ir = ir;
		p.typed = 1'b0;
		pending_pairs.push_back(p);
	endtask

	// Mostly pairs aimed at a chosen ratio so every band is well populated.
	task automatic add_random_pairs(input int count);
		logic [tclc_pkg::CountW-1:0] bb;
		logic [31:0] target;
		logic [47:0] ir;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0, 1: add_pair(16'($urandom), 16'($urandom));
				2: add_pair(16'($urandom_range(255)), 16'($urandom_range(255)));
				3: add_pair(16'($urandom_range(3)), 16'($urandom));
				default: begin
					bb = 16'($urandom_range(65535, 1));
					target = $urandom_range(23000);
					ir = (48'(target) * bb) >> 14;
					if (ir > 48'hFFFF) ir = 48'hFFFF;
					add_pair(bb, ir[15:0]);
				end
			endcase
		end
	endtask

	pair_t directed_rows[] = '{
		'{16'd0,     16'd0,     1'b1, 20'd0, tclc_pkg::BandOff, 1'b0},
		'{16'd0,     16'hFFFF,  1'b1, 20'd0, tclc_pkg::BandOff, 1'b0},
		'{16'd1,     16'hFFFF,  1'b1, 20'd0, tclc_pkg::BandOff, 1'b0},
		'{16'd16384, 16'd21300, 1'b1, 20'd0, tclc_pkg::BandOff, 1'b0},
		'{16'hFFFF,  16'd0,     1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'd1,     16'd0,     1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'hFFFF,  16'hFFFF,  1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'd1,     16'd1,     1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'd16384, 16'd8192,  1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'd16384, 16'd8193,  1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'd16384, 16'd9994,  1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'd16384, 16'd9995,  1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'd16384, 16'd13107, 1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'd16384, 16'd13108, 1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'd16384, 16'd21299, 1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'd40000, 16'd4000,  1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'h8000,  16'h5555,  1'b0, 20'd0, tclc_pkg::BandLow, 1'b0},
		'{16'h5555,  16'h2AAA,  1'b0, 20'd0, tclc_pkg::BandLow, 1'b0}
	};

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		broadband_count = '0;
		infrared_count = '0;
		out_ready = 1'b0;
		scale_now = 13'd256;
		idle_pct = 20;
		errors = 0;
		quiet_cycles = 0;
		for (int i = 0; i <= PowEntries; i++) power_rom[i] = power_floor(i);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) pending_pairs.push_back(directed_rows[i]);
		wait_drained();
		// The largest scale reruns the directed counts before random traffic.
		write_scale(13'd8191);
		foreach (directed_rows[i]) if (!directed_rows[i].typed)
			add_pair(directed_rows[i].bb, directed_rows[i].ir);
		add_random_pairs(120);
		wait_drained();
		write_scale(13'd1);
		add_random_pairs(100);
		wait_drained();
		// No idling at all through this phase.
		idle_pct = 0;
		write_scale(13'($urandom_range(8191, 1)));
		add_random_pairs(130);
		wait_drained();
		idle_pct = 20;
		write_scale(13'd0);
		add_random_pairs(40);
		wait_drained();
		write_scale(13'($urandom_range(8191, 1)));
		add_random_pairs(120);
		wait_drained();
		write_scale(13'd256);
		add_random_pairs(90);
		wait_drained();

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
